// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the RTL; they expect clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define FSMK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define FSMK_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/fsmk_pkg.sv -----
// ----------------------------------------------------------------------------
// fsmk_pkg
// Shared widths, defaults and control types of the flow shop makespan unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsmk_pkg;

    localparam int JOB_INDEX_W      = 10;
    localparam int MACH_INDEX_W     = 6;
    localparam int PTIME_W          = 16;
    localparam int CTIME_W          = 32;
    localparam int NUM_MACH_W       = 7;
    localparam int DEF_MAX_JOBS     = 1024;
    localparam int DEF_MAX_MACHINES = 64;

    localparam logic MODE_WRITE    = 1'b0;
    localparam logic MODE_SCHEDULE = 1'b1;

    typedef struct packed {
        logic                    seq_clear;
        logic                    rd_en;
        logic                    first;
        logic [MACH_INDEX_W-1:0] rd_addr;
    } row_ctrl_t;

    typedef struct packed {
        logic [CTIME_W-1:0] ctime;
        logic               ovf;
    } row_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fsmk_idx_reduce.sv -----
// ----------------------------------------------------------------------------
// fsmk_idx_reduce
// Multi-cycle reduction of job and machine indexes modulo the table bounds,
// one shifted compare-and-subtract per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsmk_idx_reduce #(
    parameter int MAX_JOBS     = fsmk_pkg::DEF_MAX_JOBS,
    parameter int MAX_MACHINES = fsmk_pkg::DEF_MAX_MACHINES,
    parameter int JOB_AW       = 10,
    parameter int MACH_AW      = 6
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire logic [fsmk_pkg::JOB_INDEX_W-1:0]  job_in,
    input  wire logic [fsmk_pkg::MACH_INDEX_W-1:0] mach_in,
    output logic                                   busy,
    output logic [JOB_AW-1:0]                      job_out,
    output logic [MACH_AW-1:0]                     mach_out
);
    import fsmk_pkg::*;

    localparam int JK     = (JOB_INDEX_W > $clog2(MAX_JOBS)) ?
                            JOB_INDEX_W - $clog2(MAX_JOBS) : 0;
    localparam int MK     = (MACH_INDEX_W > $clog2(MAX_MACHINES)) ?
                            MACH_INDEX_W - $clog2(MAX_MACHINES) : 0;
    localparam int KSTART = (JK > MK) ? JK : MK;
    localparam int KW     = (KSTART > 0) ? $clog2(KSTART + 1) : 1;

    logic [JOB_INDEX_W-1:0]  job_reg,  job_next;
    logic [MACH_INDEX_W-1:0] mach_reg, mach_next;
    logic [KW-1:0]           k_reg,    k_next;
    logic                    active_reg, active_next;

    always_comb
    begin
        job_next    = job_reg;
        mach_next   = mach_reg;
        k_next      = k_reg;
        active_next = active_reg;
        if (load)
        begin
            job_next    = job_in;
            mach_next   = mach_in;
            k_next      = KW'(KSTART);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            if (32'(job_reg >> k_reg) >= 32'(MAX_JOBS))
                job_next = job_reg - JOB_INDEX_W'(MAX_JOBS << k_reg);
            if (32'(mach_reg >> k_reg) >= 32'(MAX_MACHINES))
                mach_next = mach_reg - MACH_INDEX_W'(MAX_MACHINES << k_reg);
            if (k_reg == '0)
                active_next = 1'b0;
            else
                k_next = k_reg - KW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            k_reg      <= '0;
        end
        else
        begin
            active_reg <= active_next;
            k_reg      <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        mach_reg <= mach_next;
    end

    assign busy     = active_reg;
    assign job_out  = JOB_AW'(job_reg);
    assign mach_out = MACH_AW'(mach_reg);

endmodule

`default_nettype wire

// ----- hw/rtl/fsmk_ptime_mem.sv -----
// ----------------------------------------------------------------------------
// fsmk_ptime_mem
// Processing time table: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsmk_ptime_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [AW-1:0]                 waddr,
    input  wire logic [fsmk_pkg::PTIME_W-1:0]  wdata,
    input  wire logic                          re,
    input  wire logic [AW-1:0]                 raddr,
    output logic [fsmk_pkg::PTIME_W-1:0]       rdata
);
    import fsmk_pkg::*;

    logic [PTIME_W-1:0] mem [0:DEPTH-1];
    logic [PTIME_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/fsmk_row_engine.sv -----
// ----------------------------------------------------------------------------
// fsmk_row_engine
// Completion row memory with per-entry valid bits, and the saturating
// max-plus update that walks it one machine per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsmk_row_engine #(
    parameter int MAX_MACHINES = fsmk_pkg::DEF_MAX_MACHINES,
    parameter int MACH_AW      = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fsmk_pkg::row_ctrl_t           ctrl,
    input  wire logic [fsmk_pkg::PTIME_W-1:0]  ptime,
    output fsmk_pkg::row_stat_t                stat
);
    import fsmk_pkg::*;

    logic [CTIME_W-1:0]      row_mem [0:MAX_MACHINES-1];
    logic [MAX_MACHINES-1:0] vld_reg;
    logic [CTIME_W-1:0]      row_q_reg;
    logic                    vld_q_reg;
    logic                    s1_vld_reg;
    logic                    s1_first_reg;
    logic [MACH_AW-1:0]      s1_addr_reg;
    logic [CTIME_W-1:0]      prev_reg, prev_next;
    logic                    ovf_reg,  ovf_next;
    logic [MACH_AW-1:0]      rd_idx;
    logic [CTIME_W-1:0]      old_val, prev_val, max_val;
    logic [CTIME_W:0]        sum;

    assign rd_idx = ctrl.rd_addr[MACH_AW-1:0];

    always_comb
    begin
        old_val   = vld_q_reg ? row_q_reg : '0;
        prev_val  = s1_first_reg ? '0 : prev_reg;
        max_val   = (old_val > prev_val) ? old_val : prev_val;
        sum       = {1'b0, max_val} + (CTIME_W + 1)'(ptime);
        prev_next = prev_reg;
        ovf_next  = ovf_reg;
        if (ctrl.seq_clear)
            ovf_next = 1'b0;
        else if (s1_vld_reg)
        begin
            prev_next = sum[CTIME_W] ? '1 : sum[CTIME_W-1:0];
            ovf_next  = ovf_reg | sum[CTIME_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            s1_vld_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= ctrl.rd_en;
            ovf_reg    <= ovf_next;
            if (ctrl.seq_clear)
                vld_reg <= '0;
            else if (s1_vld_reg)
                vld_reg[s1_addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            row_q_reg    <= row_mem[rd_idx];
            vld_q_reg    <= vld_reg[rd_idx];
            s1_addr_reg  <= rd_idx;
            s1_first_reg <= ctrl.first;
        end
        if (s1_vld_reg)
            row_mem[s1_addr_reg] <= prev_next;
        prev_reg <= prev_next;
    end

    assign stat.ctime = prev_reg;
    assign stat.ovf   = ovf_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/flow_shop_makespan_unit.sv -----
// ----------------------------------------------------------------------------
// flow_shop_makespan_unit
// Permutation flow shop completion times over a job-by-machine table.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the item is finished. Index reduction takes one step at the default sizes.
// The walk over the completion row memory reads one machine entry per cycle
// through its single read port. A mode 1 item's result is shown for one cycle
// with done high, in the last cycle of the item; the receiver must take it
// then. The user must write num_machines through cfg_we and cfg_wdata only
// while busy is low; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module flow_shop_makespan_unit #(
    parameter int MAX_JOBS     = fsmk_pkg::DEF_MAX_JOBS,
    parameter int MAX_MACHINES = fsmk_pkg::DEF_MAX_MACHINES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              mode,
    input  wire logic [fsmk_pkg::JOB_INDEX_W-1:0]  job_index,
    input  wire logic [fsmk_pkg::MACH_INDEX_W-1:0] machine_index,
    input  wire logic [fsmk_pkg::PTIME_W-1:0]      proc_time,
    input  wire logic                              last_job,
    input  wire logic                              cfg_we,
    input  wire logic [fsmk_pkg::NUM_MACH_W-1:0]   cfg_wdata,
    output logic                                   done,
    output logic [fsmk_pkg::CTIME_W-1:0]           completion_time,
    output logic                                   is_last,
    output logic                                   saturated
);
    import fsmk_pkg::*;

    localparam int JOB_AW    = $clog2(MAX_JOBS);
    localparam int MACH_AW   = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int TAB_DEPTH = MAX_JOBS * MAX_MACHINES;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_WALK   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [MACH_AW-1:0]     walk_m_reg, walk_m_next;
    logic                   fresh_reg, fresh_next;
    logic [NUM_MACH_W-1:0]  nm_reg;
    logic                   mode_reg, last_reg;
    logic [PTIME_W-1:0]     ptime_reg;
    logic                   accept;
    logic [NUM_MACH_W-1:0]  n_eff;
    logic                   red_busy;
    logic [JOB_AW-1:0]      job_red;
    logic [MACH_AW-1:0]     mach_red;
    logic [TAB_AW-1:0]      tab_base;
    logic                   tab_we;
    logic [TAB_AW-1:0]      tab_waddr, tab_raddr;
    logic [PTIME_W-1:0]     tab_rdata;
    logic                   walk_last;
    row_ctrl_t              row_ctrl;
    row_stat_t              row_stat;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        if (nm_reg == '0)
            n_eff = NUM_MACH_W'(1);
        else if (nm_reg > NUM_MACH_W'(MAX_MACHINES))
            n_eff = NUM_MACH_W'(MAX_MACHINES);
        else
            n_eff = nm_reg;
    end

    fsmk_idx_reduce #(
        .MAX_JOBS     (MAX_JOBS),
        .MAX_MACHINES (MAX_MACHINES),
        .JOB_AW       (JOB_AW),
        .MACH_AW      (MACH_AW)
    ) u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .job_in   (job_index),
        .mach_in  (machine_index),
        .busy     (red_busy),
        .job_out  (job_red),
        .mach_out (mach_red)
    );

    assign tab_base  = TAB_AW'(job_red) * TAB_AW'(MAX_MACHINES);
    assign tab_waddr = tab_base + TAB_AW'(mach_red);
    assign tab_raddr = tab_base + TAB_AW'(walk_m_reg);
    assign tab_we    = (state_reg == ST_REDUCE) && !red_busy && (mode_reg == MODE_WRITE);
    assign walk_last = (NUM_MACH_W'(walk_m_reg) == n_eff - NUM_MACH_W'(1));

    fsmk_ptime_mem #(
        .DEPTH (TAB_DEPTH),
        .AW    (TAB_AW)
    ) u_ptime (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (ptime_reg),
        .re    (row_ctrl.rd_en),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    always_comb
    begin
        row_ctrl.seq_clear = accept && (mode == MODE_SCHEDULE) && fresh_reg;
        row_ctrl.rd_en     = (state_reg == ST_WALK);
        row_ctrl.first     = (walk_m_reg == '0);
        row_ctrl.rd_addr   = MACH_INDEX_W'(walk_m_reg);
    end

    fsmk_row_engine #(
        .MAX_MACHINES (MAX_MACHINES),
        .MACH_AW      (MACH_AW)
    ) u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (row_ctrl),
        .ptime (tab_rdata),
        .stat  (row_stat)
    );

    always_comb
    begin
        state_next  = state_reg;
        walk_m_next = walk_m_reg;
        fresh_next  = fresh_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_REDUCE;
                    if (mode == MODE_SCHEDULE)
                        fresh_next = last_job;
                end
            end
            ST_REDUCE:
            begin
                walk_m_next = '0;
                if (!red_busy)
                    state_next = (mode_reg == MODE_SCHEDULE) ? ST_WALK : ST_IDLE;
            end
            ST_WALK:
            begin
                if (walk_last)
                    state_next = ST_DRAIN;
                else
                    walk_m_next = walk_m_reg + MACH_AW'(1);
            end
            ST_DRAIN:
                state_next = ST_EMIT;
            ST_EMIT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            walk_m_reg <= '0;
            fresh_reg  <= 1'b1;
            nm_reg     <= NUM_MACH_W'(1);
            mode_reg   <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            walk_m_reg <= walk_m_next;
            fresh_reg  <= fresh_next;
            if (cfg_we)
                nm_reg <= cfg_wdata;
            if (accept)
            begin
                mode_reg <= mode;
                last_reg <= last_job;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ptime_reg <= proc_time;
    end

    assign done            = (state_reg == ST_EMIT);
    assign completion_time = row_stat.ctime;
    assign is_last         = last_reg;
    assign saturated       = row_stat.ovf;

    `FSMK_NEVER(a_walk_in_range, (state_reg == ST_WALK) && (NUM_MACH_W'(walk_m_reg) >= n_eff), "walk index beyond machine count")
    `FSMK_NEVER(a_reduce_idle_in_walk, (state_reg == ST_WALK) && red_busy, "index reduction still running during walk")
    `FSMK_NEVER(a_no_write_in_walk, tab_we && row_ctrl.rd_en, "table write overlaps row walk")
    `FSMK_ASSERT(a_done_after_drain, done |-> $past(state_reg == ST_DRAIN), "result shown without drained row")

endmodule

`default_nettype wire

// ----- dv/makespan_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// makespan_checker
// Watches the item, result and register channels of the flow shop makespan
// unit, keeps its own copy of the time table and completion row, predicts
// each scheduled job's completion and compares it with the result port.
// ----------------------------------------------------------------------------

module makespan_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              mode,
    input  logic [fsmk_pkg::JOB_INDEX_W-1:0]  job_index,
    input  logic [fsmk_pkg::MACH_INDEX_W-1:0] machine_index,
    input  logic [fsmk_pkg::PTIME_W-1:0]      proc_time,
    input  logic                              last_job,
    input  logic                              cfg_we,
    input  logic [fsmk_pkg::NUM_MACH_W-1:0]   cfg_wdata,
    input  logic                              done,
    input  logic [fsmk_pkg::CTIME_W-1:0]      completion_time,
    input  logic                              is_last,
    input  logic                              saturated,
    output int                                mismatches,
    output int                                outstanding,
    output int                                completions,
    output int                                saturations
);

    localparam logic MODE_WRITE    = fsmk_pkg::MODE_WRITE;
    localparam logic MODE_SCHEDULE = fsmk_pkg::MODE_SCHEDULE;
    localparam int   NJOBS         = fsmk_pkg::DEF_MAX_JOBS;
    localparam int   NMACH         = fsmk_pkg::DEF_MAX_MACHINES;
    localparam int   REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [fsmk_pkg::CTIME_W-1:0] ctime;
        logic                         last;
        logic                         sat;
    } makespan_t;

    logic [fsmk_pkg::PTIME_W-1:0]    ptime_tbl [NJOBS*NMACH];
    logic [fsmk_pkg::CTIME_W-1:0]    finish_row [NMACH];
    logic                            seq_fresh;
    logic                            ovf_seen;
    logic [fsmk_pkg::NUM_MACH_W-1:0] mach_cnt;
    makespan_t                       makespan_q [$];
    int                              err_cnt;
    int                              done_cnt;
    int                              sat_cnt;

    function automatic int unsigned routed_machines(logic [fsmk_pkg::NUM_MACH_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > NMACH)
            return NMACH;
        return 32'(v);
    endfunction

    function automatic makespan_t predict_makespan(logic [fsmk_pkg::JOB_INDEX_W-1:0] job,
                                                   logic last);
        int unsigned                  n;
        logic [fsmk_pkg::CTIME_W:0]   sum;
        logic [fsmk_pkg::CTIME_W-1:0] ready;
        makespan_t                    res;
        if (seq_fresh)
        begin
            foreach (finish_row[i])
                finish_row[i] = '0;
            ovf_seen  = 1'b0;
            seq_fresh = 1'b0;
        end
        n = routed_machines(mach_cnt);
        for (int m = 0; m < n; m++)
        begin
            ready = finish_row[m];
            if (m > 0)
            begin
                if (finish_row[m-1] > ready)
                    ready = finish_row[m-1];
            end
            sum = {1'b0, ready} + {17'd0, ptime_tbl[{job, 6'(m)}]};
            if (sum[fsmk_pkg::CTIME_W])
            begin
                ovf_seen      = 1'b1;
                finish_row[m] = '1;
            end
            else
                finish_row[m] = sum[fsmk_pkg::CTIME_W-1:0];
        end
        res.ctime = finish_row[n-1];
        res.last  = last;
        res.sat   = ovf_seen;
        if (last)
            seq_fresh = 1'b1;
        return res;
    endfunction

    task automatic check_completion();
        makespan_t exp_res;
        done_cnt++;
        if (saturated === 1'b1)
            sat_cnt++;
        if (makespan_q.size() == 0)
        begin
            err_cnt++;
            if (err_cnt <= REPORT_LIMIT)
                $display("%t: unexpected completion %h is_last %b saturated %b",
                         $realtime, completion_time, is_last, saturated);
        end
        else
        begin
            exp_res = makespan_q.pop_front();
            if (completion_time !== exp_res.ctime || is_last !== exp_res.last ||
                saturated !== exp_res.sat)
            begin
                err_cnt++;
                if (err_cnt <= REPORT_LIMIT)
                    $display("%t: completion exp %h/%b/%b got %h/%b/%b (time/last/sat)",
                             $realtime, exp_res.ctime, exp_res.last, exp_res.sat,
                             completion_time, is_last, saturated);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (finish_row[i])
                finish_row[i] = '0;
            seq_fresh = 1'b1;
            ovf_seen  = 1'b0;
            mach_cnt  = 7'd1;
            makespan_q.delete();
            err_cnt   = 0;
            done_cnt  = 0;
            sat_cnt   = 0;
        end
        else
        begin
            if (done)
                check_completion();
            if (start && !busy)
            begin
                if (mode == MODE_WRITE)
                    ptime_tbl[{job_index, machine_index}] = proc_time;
                else if (mode == MODE_SCHEDULE)
                    makespan_q.push_back(predict_makespan(job_index, last_job));
            end
            if (cfg_we)
                mach_cnt = cfg_wdata;
        end
        mismatches  <= err_cnt;
        outstanding <= makespan_q.size();
        completions <= done_cnt;
        saturations <= sat_cnt;
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the flow shop makespan unit with table writes and job schedules:
// a directed opening and random phases of sequences over several machine
// counts. Results are predicted and compared by makespan_checker.
// ----------------------------------------------------------------------------

module tb;

    localparam logic MODE_WRITE    = fsmk_pkg::MODE_WRITE;
    localparam logic MODE_SCHEDULE = fsmk_pkg::MODE_SCHEDULE;
    localparam int   IDLE_PAUSE    = 100;
    localparam int   RANDOM_ITEMS  = 800;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic                              mode;
    logic [fsmk_pkg::JOB_INDEX_W-1:0]  job_index;
    logic [fsmk_pkg::MACH_INDEX_W-1:0] machine_index;
    logic [fsmk_pkg::PTIME_W-1:0]      proc_time;
    logic                              last_job;
    logic                              cfg_we;
    logic [fsmk_pkg::NUM_MACH_W-1:0]   cfg_wdata;
    logic                              done;
    logic [fsmk_pkg::CTIME_W-1:0]      completion_time;
    logic                              is_last;
    logic                              saturated;

    int          mismatches;
    int          outstanding;
    int          completions;
    int          saturations;
    int          items_sent;
    int          random_end;
    int unsigned mach_eff;
    bit          steady;
    bit          ptime_known [1024][64];
    logic [9:0]  job_pool [4];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    flow_shop_makespan_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .job_index       (job_index),
        .machine_index   (machine_index),
        .proc_time       (proc_time),
        .last_job        (last_job),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .completion_time (completion_time),
        .is_last         (is_last),
        .saturated       (saturated)
    );

    makespan_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .job_index       (job_index),
        .machine_index   (machine_index),
        .proc_time       (proc_time),
        .last_job        (last_job),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .completion_time (completion_time),
        .is_last         (is_last),
        .saturated       (saturated),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .completions     (completions),
        .saturations     (saturations)
    );

    function automatic logic [15:0] pick_ptime();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        if (r < 5)
            return 16'($urandom_range(1, 20));
        return 16'($urandom);
    endfunction

    task automatic issue(input logic op, input logic [9:0] job, input logic [5:0] mach,
                         input logic [15:0] pt, input logic last);
        int unsigned gap;
        int unsigned r;
        mode          <= op;
        job_index     <= job;
        machine_index <= mach;
        proc_time     <= pt;
        last_job      <= last;
        start         <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (op == MODE_WRITE)
            ptime_known[job][mach] = 1'b1;
        gap = 0;
        if (!steady)
        begin
            r = $urandom_range(0, 99);
            if (r >= 97)
                gap = $urandom_range(20, 60);
            else if (r >= 85)
                gap = $urandom_range(4, 12);
            else if (r >= 50)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic schedule(input logic [9:0] job, input logic last);
        issue(MODE_SCHEDULE, job, 6'($urandom), 16'($urandom), last);
    endtask

    task automatic prepare_job(input logic [9:0] job);
        for (int m = 0; m < mach_eff; m++)
        begin
            if (!ptime_known[job][m])
                issue(MODE_WRITE, job, 6'(m), pick_ptime(), 1'($urandom));
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [6:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mach_eff = (v == 0) ? 1 : (v > 64) ? 64 : v;
    endtask

    initial
    begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int unsigned r;
        int unsigned nseq;
        int unsigned njobs;
        int unsigned len;
        logic [6:0]  cnt;
        logic [9:0]  pj;
        bit          open_end;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        mode          <= 1'b0;
        job_index     <= '0;
        machine_index <= '0;
        proc_time     <= '0;
        last_job      <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        items_sent = 0;
        steady     = 1'b0;
        mach_eff   = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // zero count acts as one machine
        write_cfg(7'd0);
        issue(MODE_WRITE, 10'd0, 6'd0, 16'h0000, 1'b1);
        issue(MODE_WRITE, 10'h3FF, 6'd0, 16'hFFFF, 1'b0);
        issue(MODE_WRITE, 10'h3FF, 6'h3F, 16'hFFFF, 1'b1);
        issue(MODE_WRITE, 10'h3FF, 6'd1, 16'h0001, 1'b0);
        issue(MODE_WRITE, 10'h3FF, 6'd2, 16'h8000, 1'b0);
        issue(MODE_WRITE, 10'd1, 6'd0, 16'h0007, 1'b0);
        issue(MODE_WRITE, 10'd1, 6'd1, 16'hFFFF, 1'b0);
        issue(MODE_WRITE, 10'd1, 6'd2, 16'h0003, 1'b0);
        schedule(10'd0, 1'b0);
        schedule(10'h3FF, 1'b0);
        schedule(10'd0, 1'b1);
        write_cfg(7'd3);
        schedule(10'h3FF, 1'b0);
        issue(MODE_WRITE, 10'd1, 6'd1, 16'h0000, 1'b0);
        schedule(10'd1, 1'b0);
        schedule(10'd1, 1'b1);

        random_end = items_sent + RANDOM_ITEMS;
        while (items_sent < random_end)
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
            begin
                case ($urandom_range(0, 4))
                    0: cnt = 7'd0;
                    1: cnt = 7'd1;
                    2: cnt = 7'd64;
                    3: cnt = 7'd65;
                    default: cnt = 7'd127;
                endcase
            end
            else if (r < 3)
                cnt = 7'($urandom_range(9, 63));
            else
                cnt = 7'($urandom_range(1, 8));
            write_cfg(cnt);
            steady = ($urandom_range(0, 3) == 0);
            nseq = $urandom_range(1, 3);
            for (int s = 0; s < nseq; s++)
            begin
                njobs = $urandom_range(1, 4);
                for (int j = 0; j < njobs; j++)
                begin
                    job_pool[j] = ($urandom_range(0, 7) == 0) ? 10'h3FF : 10'($urandom);
                    prepare_job(job_pool[j]);
                end
                len = $urandom_range(1, 6);
                open_end = (s == nseq - 1) && ($urandom_range(0, 6) == 0);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        issue(MODE_WRITE, 10'($urandom), 6'($urandom), pick_ptime(),
                              1'($urandom));
                    pj = job_pool[$urandom_range(0, njobs - 1)];
                    if ($urandom_range(0, 5) == 0)
                        issue(MODE_WRITE, pj, 6'($urandom_range(0, mach_eff - 1)),
                              pick_ptime(), 1'($urandom));
                    schedule(pj, (k == len - 1) && !open_end);
                end
            end
        end

        settle();
        $display("Accepted %0d items over machine counts 0 to 127; %0d completions checked",
                 items_sent, completions);
        $display("%0d completions carried the saturation flag", saturations);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
